@@ rtl/priority_timed_slot_queue_macros.svh @@
// assertion macros shared by the rtl
`ifndef PRIORITY_TIMED_SLOT_QUEUE_MACROS_SVH
`define PRIORITY_TIMED_SLOT_QUEUE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PTS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define PTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/pts_pkg.sv @@
`timescale 1ns / 1ps

package pts_pkg;

   localparam int SLOT_W = 4;
   localparam int TAG_W = 32;
   localparam int LEN_W = 8;
   localparam int TIME_W = 32;

   localparam logic [1:0] MODE_PUSH = 2'd0;
   localparam logic [1:0] MODE_PEEK = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;

   localparam logic [1:0] PART_HIGH = 2'd0;
   localparam logic [1:0] PART_MEDIUM = 2'd1;
   localparam logic [1:0] PART_LOW = 2'd2;
   localparam logic [1:0] PRIO_ALT_LOW = 2'd3;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;
   localparam logic [1:0] STATUS_NONE = 2'd3;

   typedef struct packed {
      logic eval;
      logic push;
      logic remove;
      logic [1:0] part;
      logic [SLOT_W-1:0] slot_index;
      logic [TAG_W-1:0] tag;
      logic [LEN_W-1:0] len;
      logic [TIME_W-1:0] release_time;
      logic [TIME_W-1:0] now_time;
   } cmd_type;

   typedef struct packed {
      logic found;
      logic [SLOT_W-1:0] slot;
      logic [TAG_W-1:0] tag;
      logic [LEN_W-1:0] len;
      logic [TIME_W-1:0] release_time;
      logic taken;
      logic [SLOT_W-1:0] push_slot;
   } chain_type;

endpackage

@@ rtl/pts_cell.sv @@
`timescale 1ns / 1ps

module pts_cell #(
   parameter int INDEX = 0,
   parameter logic [1:0] PART = 2'd0
) (
   input  logic                clock,
   input  logic                reset,
   input  pts_pkg::cmd_type    cmd,
   input  pts_pkg::chain_type  chain_in,
   output pts_pkg::chain_type  chain_out
);
   import pts_pkg::*;

   localparam logic [SLOT_W-1:0] CELL_SLOT = SLOT_W'(INDEX);
   localparam logic IN_RANGE = (INDEX < (1 << SLOT_W));

   logic used_ff, used_in;
   logic ready_ff, ready_in;
   logic free_ff, free_in;
   logic [TAG_W-1:0] tag_ff;
   logic [LEN_W-1:0] len_ff;
   logic [TIME_W-1:0] rel_ff;
   logic [TIME_W-1:0] diff;
   logic claim;
   logic hit_remove;

   always_comb begin
      diff = cmd.now_time - rel_ff;
      ready_in = ready_ff;
      free_in = free_ff;
      if (cmd.eval) begin
         ready_in = used_ff && ((rel_ff == '0) || !diff[TIME_W-1]);
         free_in = !used_ff && (cmd.part == PART);
      end
   end

   assign claim = !chain_in.taken && free_ff;
   assign hit_remove = cmd.remove && IN_RANGE && (cmd.slot_index == CELL_SLOT);

   always_comb begin
      used_in = used_ff;
      if (cmd.push && claim) begin
         used_in = 1'b1;
      end
      if (hit_remove) begin
         used_in = 1'b0;
      end
   end

   // pass the first ready slot and the first free slot along the row
   always_comb begin
      chain_out = chain_in;
      if (!chain_in.found && ready_ff) begin
         chain_out.found = 1'b1;
         chain_out.slot = CELL_SLOT;
         chain_out.tag = tag_ff;
         chain_out.len = len_ff;
         chain_out.release_time = rel_ff;
      end
      if (claim) begin
         chain_out.taken = 1'b1;
         chain_out.push_slot = CELL_SLOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         ready_ff <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         ready_ff <= ready_in;
         free_ff <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push && claim) begin
         tag_ff <= cmd.tag;
         len_ff <= cmd.len;
         rel_ff <= cmd.release_time;
      end
   end

endmodule

@@ rtl/priority_timed_slot_queue.sv @@
`timescale 1ns / 1ps
// Slot queue with high, medium and low partitions and per-frame release times.
// Request channel: req_valid with req_stall; a request is taken when the block
// is idle. mode 0 pushes a frame into the lowest free slot of its partition,
// mode 1 peeks the first ready slot in priority then index order, mode 2 frees
// a slot by index.
// Response channel: rsp_valid with rsp_stall; every request gives exactly one
// response, held in an output register until taken.
// A request passes through two steps: the EVAL state, in which every slot cell
// evaluates its ready and free flags in parallel, then the COMMIT state, in
// which the row of cells passes the first hit along and the winning cell is
// written. A new request is taken only back in the idle state, after the
// previous one has left COMMIT.
// A new request is taken while a response waits; if the receiver still stalls
// the previous response, the new one waits in its second step until the
// output register frees, and no slot is updated before then.
// Reset frees every slot and clears both channels' control state.

`include "priority_timed_slot_queue_macros.svh"

module priority_timed_slot_queue #(
   parameter int HIGH_SLOTS = 4,
   parameter int MEDIUM_SLOTS = 4,
   parameter int LOW_SLOTS = 8,
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_mode,
   input  logic [1:0]                      req_priority_req,
   input  logic [pts_pkg::TAG_W-1:0]       req_frame_tag,
   input  logic [pts_pkg::LEN_W-1:0]       req_payload_length,
   input  logic [pts_pkg::TIME_W-1:0]      req_release_time,
   input  logic [pts_pkg::TIME_W-1:0]      req_now_time,
   input  logic [pts_pkg::SLOT_W-1:0]      req_slot_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_found,
   output logic [pts_pkg::SLOT_W-1:0]      rsp_out_slot,
   output logic [pts_pkg::TAG_W-1:0]       rsp_out_tag,
   output logic [pts_pkg::LEN_W-1:0]       rsp_out_length,
   output logic [pts_pkg::TIME_W-1:0]      rsp_out_release
);
   import pts_pkg::*;

   localparam int TOTAL_SLOTS = HIGH_SLOTS + MEDIUM_SLOTS + LOW_SLOTS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [1:0] mode_ff;
   logic [1:0] part_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [LEN_W-1:0] len_ff;
   logic [TIME_W-1:0] rel_ff;
   logic [TIME_W-1:0] now_ff;
   logic [SLOT_W-1:0] idx_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] status_ff, status_in;
   logic found_ff, found_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [TAG_W-1:0] out_tag_ff, out_tag_in;
   logic [LEN_W-1:0] out_len_ff, out_len_in;
   logic [TIME_W-1:0] out_rel_ff, out_rel_in;

   logic accept;
   logic out_free;
   logic finish;
   logic len_ok;
   cmd_type cmd;
   chain_type chain_w [0:TOTAL_SLOTS];

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign finish = (state_ff == ST_COMMIT) && out_free;
   assign len_ok = (len_ff <= LEN_W'(MAX_PAYLOAD));

   always_comb begin
      cmd.eval = (state_ff == ST_EVAL);
      cmd.push = finish && (mode_ff == MODE_PUSH) && len_ok;
      cmd.remove = finish && (mode_ff == MODE_REMOVE);
      cmd.part = part_ff;
      cmd.slot_index = idx_ff;
      cmd.tag = tag_ff;
      cmd.len = len_ff;
      cmd.release_time = rel_ff;
      cmd.now_time = now_ff;
   end

   assign chain_w[0] = '0;

   for (genvar i = 0; i < TOTAL_SLOTS; i++) begin : g_cell
      localparam logic [1:0] CELL_PART = (i < HIGH_SLOTS) ? PART_HIGH :
         (i < HIGH_SLOTS + MEDIUM_SLOTS) ? PART_MEDIUM : PART_LOW;
      pts_cell #(
         .INDEX(i),
         .PART (CELL_PART)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .chain_in (chain_w[i]),
         .chain_out(chain_w[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in = status_ff;
      found_in = found_ff;
      slot_in = slot_ff;
      out_tag_in = out_tag_ff;
      out_len_in = out_len_ff;
      out_rel_in = out_rel_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         status_in = STATUS_OK;
         found_in = 1'b0;
         slot_in = '0;
         out_tag_in = '0;
         out_len_in = '0;
         out_rel_in = '0;
         case (mode_ff)
            MODE_PUSH: begin
               if (!len_ok) begin
                  status_in = STATUS_TOO_LONG;
               end else if (chain_w[TOTAL_SLOTS].taken) begin
                  slot_in = chain_w[TOTAL_SLOTS].push_slot;
               end else begin
                  status_in = STATUS_FULL;
               end
            end
            MODE_PEEK: begin
               if (chain_w[TOTAL_SLOTS].found) begin
                  found_in = 1'b1;
                  slot_in = chain_w[TOTAL_SLOTS].slot;
                  out_tag_in = chain_w[TOTAL_SLOTS].tag;
                  out_len_in = chain_w[TOTAL_SLOTS].len;
                  out_rel_in = chain_w[TOTAL_SLOTS].release_time;
               end else begin
                  status_in = STATUS_NONE;
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         part_ff <= (req_priority_req == PRIO_ALT_LOW) ? PART_LOW : req_priority_req;
         tag_ff <= req_frame_tag;
         len_ff <= req_payload_length;
         rel_ff <= req_release_time;
         now_ff <= req_now_time;
         idx_ff <= req_slot_index;
      end
      status_ff <= status_in;
      found_ff <= found_in;
      slot_ff <= slot_in;
      out_tag_ff <= out_tag_in;
      out_len_ff <= out_len_in;
      out_rel_ff <= out_rel_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_found = found_ff;
   assign rsp_out_slot = slot_ff;
   assign rsp_out_tag = out_tag_ff;
   assign rsp_out_length = out_len_ff;
   assign rsp_out_release = out_rel_ff;

   `PTS_ASSERT_NEXT(a_accept_eval, clock, reset, accept, state_ff == ST_EVAL)
   `PTS_ASSERT_NEXT(a_eval_commit, clock, reset, state_ff == ST_EVAL, state_ff == ST_COMMIT)
   `PTS_ASSERT_SAME(a_rsp_from_commit, clock, reset, $rose(rsp_valid_ff), $past(finish))
   `PTS_ASSERT_SAME(a_found_ok, clock, reset, rsp_valid_ff && found_ff, status_ff == STATUS_OK)

endmodule
